// ----- rtl/gscd_pkg.sv -----
package gscd_pkg;

   // Field widths fixed by the interface.
   localparam int COV_W   = 8;
   localparam int COL_W   = 7;
   localparam int PIX_W   = 32;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_PIXEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_PIXEL  = 2'd2;

   // Rows seen saturates at two.
   localparam logic [1:0] ROWS_MAX = 2'd2;

   // Up to three results produced by one request.
   typedef struct packed {
      logic             has_left;
      logic             has_right;
      logic             on_left;
      logic             on_mid;
      logic             on_right;
      logic [COL_W-1:0] mid_col;
      logic [COL_W-1:0] end_col;
   } bundle_type;

endpackage

// ----- rtl/glyph_shadow_cross_dilation_top.sv -----
// Glyph shadow generator: a plus-shaped dilation of a coverage mask.
// Requests carry one coverage byte each, in raster order, row_width per row;
// first_of_glyph marks pixel (0,0) of a new glyph. Each request yields one to
// three responses: column 0 at the start of a row, column x+1 always, and
// column row_width+1 at the end of a row, the last of them flagged by
// rsp_last_of_run. Two blank rows appended by the caller flush the image.
// The csr channel writes row_width, fg_pixel and bg_pixel; it is always ready
// and must only be used while no request is in flight.
// A request passes the read stage and output stage registers before its first
// response. A request can be taken every cycle while the output stage can load;
// the response channel bounds throughput at one result per cycle, row_width+2 per row.
// The line buffers live in one two-read, one-write memory of MAX_WIDTH words;
// a request's read happens on accept and its write-back as it leaves the read stage,
// with same-word writes passed to the read port.
// After reset the block clears all MAX_WIDTH words of that memory with
// req_ready low. When rsp_ready is low, results hold in the output stage,
// one request waits in the read stage, and then req_ready drops.
module glyph_shadow_cross_dilation_top #(
   parameter int MAX_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gscd_pkg::COV_W-1:0]        req_coverage,
   input  logic                              req_first_of_glyph,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gscd_pkg::PIX_W-1:0]        rsp_pixel_value,
   output logic [gscd_pkg::COL_W-1:0]        rsp_out_column,
   output logic                              rsp_row_end,
   output logic                              rsp_last_of_run,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gscd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gscd_pkg::PIX_W-1:0]        csr_data
);

   localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WCAP = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
   localparam logic [gscd_pkg::COL_W-1:0] WCAP_C = gscd_pkg::COL_W'(WCAP);
   localparam logic [AW-1:0] CLR_LAST = AW'(MAX_WIDTH - 1);

   // Configuration registers.
   logic [gscd_pkg::COL_W-1:0] row_width_ff;
   logic [gscd_pkg::PIX_W-1:0] fg_pixel_ff;
   logic [gscd_pkg::PIX_W-1:0] bg_pixel_ff;

   // Accept-side control state.
   logic [gscd_pkg::COL_W-1:0] column_count_ff, column_count_in;
   logic [1:0]                 rows_seen_ff, rows_seen_in;
   logic                       bank_select_ff;
   logic                       clr_busy_ff;
   logic [AW-1:0]              clr_addr_ff;

   // Read stage.
   logic                       s1_valid_ff;
   logic [gscd_pkg::COL_W-1:0] s1_x_ff;
   logic [gscd_pkg::COL_W-1:0] s1_w_ff;
   logic                       s1_last_ff;
   logic [1:0]                 s1_rows_ff;
   logic                       s1_sel_ff;
   logic                       s1_cur_ff;
   logic                       left_mask_ff, left_mask_in;

   logic                       accept;
   logic                       s1_adv;
   logic [gscd_pkg::COL_W-1:0] eff_w;
   logic [gscd_pkg::COL_W-1:0] cnt;
   logic [1:0]                 rows;
   logic [gscd_pkg::COL_W-1:0] x;
   logic                       last;

   logic                       mem_we;
   logic [AW-1:0]              mem_wa;
   logic [1:0]                 mem_wd;
   logic [1:0]                 rd0;
   logic [1:0]                 rd1;
   logic                       prev_x, older_x, prev_x1;
   logic                       above, above2, right_above, left_above;
   gscd_pkg::bundle_type       bundle;
   logic                       ob_ready;

   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= gscd_pkg::COL_W'(1);
         fg_pixel_ff  <= '0;
         bg_pixel_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            gscd_pkg::CSR_ROW_WIDTH: row_width_ff <= csr_data[gscd_pkg::COL_W-1:0];
            gscd_pkg::CSR_FG_PIXEL:  fg_pixel_ff  <= csr_data;
            gscd_pkg::CSR_BG_PIXEL:  bg_pixel_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Effective width, column and row-end decision for the incoming request.
   always_comb begin
      if (row_width_ff == '0) begin
         eff_w = gscd_pkg::COL_W'(1);
      end else if (row_width_ff > WCAP_C) begin
         eff_w = WCAP_C;
      end else begin
         eff_w = row_width_ff;
      end
      cnt  = req_first_of_glyph ? '0 : column_count_ff;
      rows = req_first_of_glyph ? 2'd0 : rows_seen_ff;
      x    = (cnt >= eff_w) ? eff_w - gscd_pkg::COL_W'(1) : cnt;
      last = (x == eff_w - gscd_pkg::COL_W'(1));
      column_count_in = last ? '0 : x + gscd_pkg::COL_W'(1);
      rows_seen_in    = (last && rows != gscd_pkg::ROWS_MAX) ? rows + 2'd1 : rows;
   end

   assign s1_adv    = s1_valid_ff && ob_ready;
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;

   // Memory clearing pass after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == CLR_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Row and column tracking, updated as each request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         rows_seen_ff    <= '0;
         bank_select_ff  <= 1'b0;
      end else if (accept) begin
         column_count_ff <= column_count_in;
         rows_seen_ff    <= rows_seen_in;
         if (last) begin
            bank_select_ff <= !bank_select_ff;
         end
      end
   end

   // Read stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff    <= x;
         s1_w_ff    <= eff_w;
         s1_last_ff <= last;
         s1_rows_ff <= rows;
         s1_sel_ff  <= bank_select_ff;
         s1_cur_ff  <= (req_coverage != '0);
      end
   end

   // Line buffer write: clearing pass, or write-back of the current row bit.
   always_comb begin
      if (clr_busy_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = 2'b00;
      end else begin
         mem_we = s1_adv;
         mem_wa = AW'(s1_x_ff);
         mem_wd = s1_sel_ff ? {rd0[1], s1_cur_ff} : {s1_cur_ff, rd0[0]};
      end
   end

   gscd_line_mem #(
      .DEPTH(MAX_WIDTH),
      .AW   (AW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (accept),
      .rd_addr0(AW'(x)),
      .rd_addr1(AW'(x + gscd_pkg::COL_W'(1))),
      .rd_data0(rd0),
      .rd_data1(rd1)
   );

   // Neighborhood taps and the three candidate results.
   always_comb begin
      prev_x      = s1_sel_ff ? rd0[1] : rd0[0];
      older_x     = s1_sel_ff ? rd0[0] : rd0[1];
      prev_x1     = s1_sel_ff ? rd1[1] : rd1[0];
      above       = (s1_rows_ff != 2'd0) && prev_x;
      above2      = (s1_rows_ff == gscd_pkg::ROWS_MAX) && older_x;
      right_above = !s1_last_ff && (s1_rows_ff != 2'd0) && prev_x1;
      left_above  = (s1_x_ff != '0) && left_mask_ff;

      bundle.has_left  = (s1_x_ff == '0);
      bundle.has_right = s1_last_ff;
      bundle.on_left   = above;
      bundle.on_mid    = s1_cur_ff | left_above | above | right_above | above2;
      bundle.on_right  = above;
      bundle.mid_col   = s1_x_ff + gscd_pkg::COL_W'(1);
      bundle.end_col   = s1_w_ff + gscd_pkg::COL_W'(1);

      left_mask_in = s1_last_ff ? 1'b0 : above;
   end

   // Mask bit of the row above at the previous column.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_mask_ff <= 1'b0;
      end else if (s1_adv) begin
         left_mask_ff <= left_mask_in;
      end
   end

   gscd_out_stage u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (s1_valid_ff),
      .load_bundle    (bundle),
      .load_ready     (ob_ready),
      .fg_pixel       (fg_pixel_ff),
      .bg_pixel       (bg_pixel_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_value(rsp_pixel_value),
      .rsp_out_column (rsp_out_column),
      .rsp_row_end    (rsp_row_end),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

// ----- rtl/gscd_line_mem.sv -----
module gscd_line_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [1:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr0,
   input  logic [AW-1:0] rd_addr1,
   output logic [1:0]    rd_data0,
   output logic [1:0]    rd_data1
);

   // Bit 0 holds line bank A, bit 1 holds line bank B, one word per column.
   logic [1:0] mem [DEPTH];
   logic [1:0] rd0_ff;
   logic [1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered reads; a write to the same word in the same cycle is passed through.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff <= (wr_en && wr_addr == rd_addr0) ? wr_data : mem[rd_addr0];
         rd1_ff <= (wr_en && wr_addr == rd_addr1) ? wr_data : mem[rd_addr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

// ----- rtl/gscd_out_stage.sv -----
module gscd_out_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load_valid,
   input  gscd_pkg::bundle_type        load_bundle,
   output logic                        load_ready,
   input  logic [gscd_pkg::PIX_W-1:0]  fg_pixel,
   input  logic [gscd_pkg::PIX_W-1:0]  bg_pixel,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gscd_pkg::PIX_W-1:0]  rsp_pixel_value,
   output logic [gscd_pkg::COL_W-1:0]  rsp_out_column,
   output logic                        rsp_row_end,
   output logic                        rsp_last_of_run
);

   typedef enum logic [1:0] {
      PH_LEFT,
      PH_MID,
      PH_RIGHT
   } phase_type;

   logic                 valid_ff;
   phase_type            phase_ff;
   gscd_pkg::bundle_type bundle_ff;
   logic                 on_now;
   logic                 done_now;

   // Current result fields.
   always_comb begin
      on_now          = 1'b0;
      rsp_out_column  = '0;
      rsp_row_end     = 1'b0;
      rsp_last_of_run = 1'b0;
      case (phase_ff)
         PH_LEFT: begin
            on_now = bundle_ff.on_left;
         end
         PH_MID: begin
            on_now          = bundle_ff.on_mid;
            rsp_out_column  = bundle_ff.mid_col;
            rsp_last_of_run = !bundle_ff.has_right;
         end
         PH_RIGHT: begin
            on_now          = bundle_ff.on_right;
            rsp_out_column  = bundle_ff.end_col;
            rsp_row_end     = 1'b1;
            rsp_last_of_run = 1'b1;
         end
         default: begin
            on_now = 1'b0;
         end
      endcase
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_value = on_now ? fg_pixel : bg_pixel;
   assign done_now        = valid_ff && rsp_ready && rsp_last_of_run;
   assign load_ready      = !valid_ff || done_now;

   // Steps through the results of one request, one per accepted response.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PH_MID;
      end else if (load_valid && load_ready) begin
         valid_ff  <= 1'b1;
         bundle_ff <= load_bundle;
         phase_ff  <= load_bundle.has_left ? PH_LEFT : PH_MID;
      end else if (done_now) begin
         valid_ff <= 1'b0;
      end else if (valid_ff && rsp_ready) begin
         case (phase_ff)
            PH_LEFT: begin
               phase_ff <= PH_MID;
            end
            PH_MID: begin
               phase_ff <= PH_RIGHT;
            end
            default: begin
               phase_ff <= PH_MID;
            end
         endcase
      end
   end

endmodule
